### hdl/ubx_pkg.sv
`timescale 1ns / 1ps

package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CKA_BAD = 2'd2;
    localparam logic [1:0] KIND_CKB_BAD = 2'd3;

    localparam logic [1:0] REG_CLASS  = 2'd0;
    localparam logic [1:0] REG_ID     = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CKA     = 9'b010000000,
        PH_CKB     = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  exp_class;
        logic [7:0]  exp_id;
        logic [15:0] exp_length;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] byte_pos;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] index;
    } t_result;

endpackage

### hdl/ubx_frame_receiver.sv
`timescale 1ns / 1ps

// channel   direction  handshake                   fields
// rx        in         i_rx_valid / o_rx_ready     i_rx_byte
// result    out        o_res_valid / i_res_ready   o_kind, o_data, o_index
// config    in         i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// one word accepted per cycle while o_rx_ready is high; the parser state updates at the accepting edge
// and a result is registered at that same edge, in the output register or, while that is held, in the skid
// a two-entry output stage (result register plus skid) lets input run on while
// a result waits; o_rx_ready drops only while the skid entry is full
// synchronous active-low reset returns to hunting and loads the register defaults

module ubx_frame_receiver
    import ubx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [15:0] o_index,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    w_res_valid;
    t_result w_res;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_accept;
    logic    w_out_take;

    assign o_rx_ready = !r_skid_valid;
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_out_take = r_out_valid && i_res_ready;

    ubx_parse u_parse (
        .i_byte      (i_rx_byte),
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_class  <= 8'd1;
            r_cfg.exp_id     <= 8'd7;
            r_cfg.exp_length <= 16'd92;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_CLASS:  r_cfg.exp_class  <= i_cfg_wdata[7:0];
                REG_ID:     r_cfg.exp_id     <= i_cfg_wdata[7:0];
                REG_LENGTH: r_cfg.exp_length <= i_cfg_wdata;
                default:    r_cfg            <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_SYNC1;
            r_state.byte_pos <= '0;
            r_state.sum_a    <= '0;
            r_state.sum_b    <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_data      = r_out.data;
    assign o_index     = r_out.index;

endmodule

### hdl/ubx_parse.sv
`timescale 1ns / 1ps

module ubx_parse
    import ubx_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  w_sum_a;
    logic [7:0]  w_sum_b;
    logic [15:0] w_pos_inc;

    assign w_sum_a   = i_state.sum_a + i_byte;
    assign w_sum_b   = i_state.sum_b + w_sum_a;
    assign w_pos_inc = i_state.byte_pos + 16'd1;

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (i_state.phase)
            PH_SYNC2: begin
                o_state.phase = (i_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                if (i_byte == i_cfg.exp_class) begin
                    o_state.sum_a = w_sum_a;
                    o_state.sum_b = w_sum_b;
                    o_state.phase = PH_ID;
                end else begin
                    o_state.phase = PH_SYNC1;
                end
            end
            PH_ID: begin
                if (i_byte == i_cfg.exp_id) begin
                    o_state.sum_a = w_sum_a;
                    o_state.sum_b = w_sum_b;
                    o_state.phase = PH_LEN_LO;
                end else begin
                    o_state.phase = PH_SYNC1;
                end
            end
            PH_LEN_LO: begin
                if (i_byte == i_cfg.exp_length[7:0]) begin
                    o_state.sum_a = w_sum_a;
                    o_state.sum_b = w_sum_b;
                    o_state.phase = PH_LEN_HI;
                end else begin
                    o_state.phase = PH_SYNC1;
                end
            end
            PH_LEN_HI: begin
                if (i_byte == i_cfg.exp_length[15:8]) begin
                    o_state.sum_a = w_sum_a;
                    o_state.sum_b = w_sum_b;
                    o_state.phase = (i_cfg.exp_length == 16'd0) ? PH_CKA : PH_PAYLOAD;
                end else begin
                    o_state.phase = PH_SYNC1;
                end
            end
            PH_PAYLOAD: begin
                o_state.sum_a    = w_sum_a;
                o_state.sum_b    = w_sum_b;
                o_state.byte_pos = w_pos_inc;
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_PAYLOAD;
                o_res.data       = i_byte;
                o_res.index      = i_state.byte_pos;
                if (w_pos_inc >= i_cfg.exp_length || w_pos_inc == 16'd0) begin
                    o_state.phase = PH_CKA;
                end
            end
            PH_CKA: begin
                if (i_byte == i_state.sum_a) begin
                    o_state.phase = PH_CKB;
                end else begin
                    o_res_valid   = 1'b1;
                    o_res.kind    = KIND_CKA_BAD;
                    o_state.phase = PH_SYNC1;
                end
            end
            PH_CKB: begin
                o_res_valid   = 1'b1;
                o_res.kind    = (i_byte == i_state.sum_b) ? KIND_GOOD : KIND_CKB_BAD;
                o_state.phase = PH_SYNC1;
            end
            default: begin
                // hunting, also any stray phase code
                if (i_byte == SYNC_FIRST) begin
                    o_state.byte_pos = '0;
                    o_state.sum_a    = '0;
                    o_state.sum_b    = '0;
                    o_state.phase    = PH_SYNC2;
                end else begin
                    o_state.phase = PH_SYNC1;
                end
            end
        endcase
    end

endmodule

### dv/tb_ubx_frame_receiver.sv
`timescale 1ns / 1ps

module tb_ubx_frame_receiver;
    import ubx_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum {FR_GOOD, FR_BAD_CKA, FR_BAD_CKB, FR_BAD_HDR, FR_BAD_SYNC2} t_fault;

    class frame_predictor;
        logic [7:0]  cls_reg;
        logic [7:0]  id_reg;
        logic [15:0] len_reg;
        t_phase      phase;
        logic [15:0] byte_pos;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        t_result     expected_words[$];
        int          mismatches;

        function new();
            cls_reg = 8'd1;
            id_reg = 8'd7;
            len_reg = 16'd92;
            phase = PH_SYNC1;
            byte_pos = '0;
            sum_a = '0;
            sum_b = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                REG_CLASS:  cls_reg = v[7:0];
                REG_ID:     id_reg = v[7:0];
                REG_LENGTH: len_reg = v;
                default:    ;
            endcase
        endfunction

        function void fold(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void take_byte(logic [7:0] c);
            t_result w;
            w = '0;
            case (phase)
                PH_SYNC2: begin
                    if (c == SYNC_SECOND) phase = PH_CLASS;
                    else phase = PH_SYNC1;
                end
                PH_CLASS: begin
                    if (c == cls_reg) begin
                        fold(c);
                        phase = PH_ID;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
                PH_ID: begin
                    if (c == id_reg) begin
                        fold(c);
                        phase = PH_LEN_LO;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
                PH_LEN_LO: begin
                    if (c == len_reg[7:0]) begin
                        fold(c);
                        phase = PH_LEN_HI;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
                PH_LEN_HI: begin
                    if (c == len_reg[15:8]) begin
                        fold(c);
                        if (len_reg == '0) phase = PH_CKA;
                        else phase = PH_PAYLOAD;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
                PH_PAYLOAD: begin
                    fold(c);
                    w.kind = KIND_PAYLOAD;
                    w.data = c;
                    w.index = byte_pos;
                    expected_words.push_back(w);
                    byte_pos = byte_pos + 16'd1;
                    if (byte_pos >= len_reg || byte_pos == '0) phase = PH_CKA;
                end
                PH_CKA: begin
                    if (c == sum_a) begin
                        phase = PH_CKB;
                    end else begin
                        w.kind = KIND_CKA_BAD;
                        expected_words.push_back(w);
                        phase = PH_SYNC1;
                    end
                end
                PH_CKB: begin
                    if (c == sum_b) w.kind = KIND_GOOD;
                    else w.kind = KIND_CKB_BAD;
                    expected_words.push_back(w);
                    phase = PH_SYNC1;
                end
                default: begin
                    if (c == SYNC_FIRST) begin
                        byte_pos = '0;
                        sum_a = '0;
                        sum_b = '0;
                        phase = PH_SYNC2;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
            endcase
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: kind %0d data 0x%02h index %0d",
                             got.kind, got.data, got.index);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/0x%02h/%0d, got %0d/0x%02h/%0d",
                                 want.kind, want.data, want.index,
                                 got.kind, got.data, got.index);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  res_kind;
    logic [7:0]  res_data;
    logic [15:0] res_index;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_CLASS;
    logic [15:0] cfg_wdata = '0;

    frame_predictor sb = new();
    int snd_idle_pct = 27;
    int rcv_idle_pct = 74;
    int hold_cnt = 0;
    int rx_count = 0;
    int idle_cycles = 0;

    ubx_frame_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rx_valid  (rx_valid),
        .o_rx_ready  (rx_ready),
        .i_rx_byte   (rx_byte),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_kind      (res_kind),
        .o_data      (res_data),
        .o_index     (res_index),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side back-pressure, with an optional long hold-off
    initial forever begin
        @(posedge clk);
        if (hold_cnt > 0) begin
            res_ready <= 1'b0;
            hold_cnt--;
        end else begin
            res_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) sb.check_word({res_kind, res_data, res_index});
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ubx_frame_receiver: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        sb.take_byte(b);
        rx_count++;
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_cfg(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len);
        logic [1:0]  regs [4];
        logic [15:0] vals [4];
        logic [7:0]  junk_a;
        logic [7:0]  junk_b;
        int k;
        junk_a = 8'($urandom);
        junk_b = 8'($urandom);
        regs = '{REG_CLASS, REG_ID, REG_LENGTH, REG_SPARE};
        vals[0] = {junk_a, cls};
        vals[1] = {junk_b, id};
        vals[2] = len;
        vals[3] = 16'($urandom);
        for (k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
            sb.write_reg(regs[k], vals[k]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // cut > 0: after cut payload words the length is lowered so the next word ends the payload
    task automatic send_frame(input t_fault f, input int cut);
        logic [7:0] body[$];
        logic [7:0] b;
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] flip;
        int n_pay;
        int bad_at;
        int i;
        flip = 8'($urandom_range(1, 255));
        body = {sb.cls_reg, sb.id_reg, sb.len_reg[7:0], sb.len_reg[15:8]};
        n_pay = (cut > 0) ? cut + 1 : int'(sb.len_reg);
        repeat (n_pay) begin
            b = 8'($urandom);
            body.push_back(b);
        end
        bad_at = $urandom_range(3);
        ck_a = '0;
        ck_b = '0;
        send_byte(SYNC_FIRST);
        if (f == FR_BAD_SYNC2) begin
            b = 8'($urandom);
            if (b == SYNC_SECOND) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(SYNC_SECOND);
        for (i = 0; i < body.size(); i++) begin
            if (cut > 0 && i == 4 + cut) begin
                wait_idle();
                program_cfg(sb.cls_reg, sb.id_reg, 16'($urandom_range(1, cut)));
            end
            b = body[i];
            if (f == FR_BAD_HDR && i == bad_at) begin
                send_byte(b ^ flip);
                return;
            end
            send_byte(b);
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
        end
        send_byte((f == FR_BAD_CKA) ? (ck_a ^ flip) : ck_a);
        if (f == FR_BAD_CKA) return;
        send_byte((f == FR_BAD_CKB) ? (ck_b ^ flip) : ck_b);
    endtask

    function automatic logic [7:0] pick_header_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    initial begin
        int phase_no;
        int target;
        int sel;
        int r;
        logic [15:0] len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, then the length is lowered mid payload
        send_frame(FR_GOOD, 3);
        wait_idle();
        // zero length goes straight to the checksum
        program_cfg(8'hFF, 8'h00, 16'h0000);
        send_frame(FR_GOOD, 0);
        send_frame(FR_BAD_CKB, 0);

        for (phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin
                    snd_idle_pct = 27;
                    rcv_idle_pct = 74;
                    target = 190;
                end
                1: begin
                    snd_idle_pct = 74;
                    rcv_idle_pct = 27;
                    target = 370;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    target = 530;
                end
            endcase
            if (phase_no == 2) begin
                wait_idle();
                program_cfg(pick_header_byte(), pick_header_byte(), 16'hFFFF);
                send_frame(FR_GOOD, 5);
                wait_idle();
                program_cfg(pick_header_byte(), pick_header_byte(), 16'd12);
                hold_cnt = 150;
                send_frame(FR_GOOD, 0);
            end
            while (rx_count < target) begin
                wait_idle();
                r = $urandom_range(9);
                if (r == 0) len = 16'd0;
                else if (r == 1) len = 16'($urandom_range(17, 24));
                else len = 16'($urandom_range(1, 8));
                program_cfg(pick_header_byte(), pick_header_byte(), len);
                repeat ($urandom_range(2, 5)) begin
                    sel = $urandom_range(99);
                    if (sel < 8) repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                    else if (sel < 66) send_frame(FR_GOOD, 0);
                    else if (sel < 74) send_frame(FR_BAD_CKA, 0);
                    else if (sel < 82) send_frame(FR_BAD_CKB, 0);
                    else if (sel < 91) send_frame(FR_BAD_HDR, 0);
                    else send_frame(FR_BAD_SYNC2, 0);
                end
            end
        end

        wait_idle();
        if (sb.expected_words.size() != 0)
            $display("%0d result words never arrived", sb.expected_words.size());
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("tb_ubx_frame_receiver: done, clean");
        end else begin
            $display("tb_ubx_frame_receiver: done, errors");
        end
        $finish;
    end

endmodule
